@@ rtl/hwt_pkg.sv @@
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared types and constants of the hashed timing wheel.
// ----------------------------------------------------------------------------
`default_nettype none

package hwt_pkg;

	localparam int LW      = 6;
	localparam logic [LW-1:0] NIL = 6'd63;
	localparam int TICK_W  = 13;
	localparam int SPAN_W  = 16;
	localparam int TAG_W   = 32;
	localparam int TMO_W   = 27;
	localparam int RND_W   = 24;
	localparam int OFF_W   = 10;
	localparam int DIV_N   = 27;
	localparam int DIV_D   = 13;

	localparam logic [TICK_W-1:0] TICK_MIN     = 13'd100;
	localparam logic [TICK_W-1:0] TICK_SUB     = 13'd10;
	localparam logic [SPAN_W-1:0] SPAN_MAX     = 16'd5000;
	localparam logic [TICK_W-1:0] TICK_RST     = 13'd100;
	localparam logic [SPAN_W-1:0] SPAN_RST     = 16'd5000;

	localparam logic REG_TICK = 1'b0;
	localparam logic REG_SPAN = 1'b1;

	localparam logic [1:0] ACT_ADD  = 2'd0;
	localparam logic [1:0] ACT_DEL  = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_EXP  = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_BUSY = 2'd1;
	localparam logic [1:0] STAT_TMO  = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CHECK,
		ST_DIVN, ST_WAITN, ST_DIVQ, ST_WAITQ, ST_DIVO, ST_WAITO, ST_DIVS, ST_WAITS,
		ST_APP_RD, ST_APP_WR1, ST_APP_WR2,
		ST_DEL_RD, ST_DEL_WR,
		ST_HEAD_RD, ST_HEAD_WT, ST_SCAN_RD, ST_SCAN_EX, ST_TICK_DONE
	} state_t;

	typedef enum logic [3:0] {
		DOP_NONE, DOP_CLEAR, DOP_LOAD, DOP_DIV_START, DOP_DIV_LATCH,
		DOP_APP_RD, DOP_APP_WR1, DOP_APP_WR2, DOP_UNLINK,
		DOP_SCAN_INIT, DOP_SCAN_RD, DOP_SCAN_EX, DOP_ADVANCE
	} dp_op_t;

	typedef enum logic [1:0] {
		DS_N, DS_Q, DS_O, DS_S
	} div_sel_t;

	typedef struct packed {
		dp_op_t     op;
		div_sel_t   div_sel;
		logic       emit;
		logic [1:0] kind;
		logic [1:0] status;
		logic       last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic [1:0] action;
		logic       idx_ok;
		logic       idx_busy;
		logic       tmo_zero;
		logic       div_done;
		logic       scan_go;
		logic       rounds_nz;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/hwt_div.sv @@
// ----------------------------------------------------------------------------
// hwt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_div import hwt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DIV_N-1:0] dividend,
	input  wire logic [DIV_D-1:0] divisor,
	output logic                  done,
	output logic      [DIV_N-1:0] quo,
	output logic      [DIV_D-1:0] rem
);

	localparam int CW = $clog2(DIV_N + 1);

	logic [DIV_N-1:0] q_q;
	logic [DIV_D-1:0] r_q;
	logic [DIV_D-1:0] d_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_D:0]   sh;
	logic [DIV_D:0]   sub;
	logic             ge;

	assign sh  = {r_q, q_q[DIV_N-1]};
	assign ge  = sh >= {1'b0, d_q};
	assign sub = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DIV_N);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			q_q <= {q_q[DIV_N-2:0], ge};
			r_q <= ge ? sub[DIV_D-1:0] : sh[DIV_D-1:0];
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

@@ rtl/hwt_ctrl.sv @@
// ----------------------------------------------------------------------------
// hwt_ctrl
// Sequencer: decodes an item and steps the datapath through its operations.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_ctrl import hwt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire dp_stat_t  st,
	output logic           busy,
	output ctrl_cmd_t      cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:     if (st.clr_last) state_nx = ST_IDLE;
			ST_IDLE:      if (start) state_nx = ST_CHECK;
			ST_CHECK: begin
				case (st.action)
					ACT_ADD: begin
						if (!st.idx_ok || st.idx_busy || st.tmo_zero) state_nx = ST_IDLE;
						else state_nx = ST_DIVN;
					end
					ACT_DEL: begin
						if (!st.idx_ok || !st.idx_busy) state_nx = ST_IDLE;
						else state_nx = ST_DEL_RD;
					end
					ACT_TICK: state_nx = ST_DIVN;
					default:  state_nx = ST_IDLE;
				endcase
			end
			ST_DIVN:      state_nx = ST_WAITN;
			ST_WAITN: begin
				if (st.div_done) begin
					state_nx = (st.action == ACT_TICK) ? ST_HEAD_RD : ST_DIVQ;
				end
			end
			ST_DIVQ:      state_nx = ST_WAITQ;
			ST_WAITQ:     if (st.div_done) state_nx = ST_DIVO;
			ST_DIVO:      state_nx = ST_WAITO;
			ST_WAITO:     if (st.div_done) state_nx = ST_DIVS;
			ST_DIVS:      state_nx = ST_WAITS;
			ST_WAITS:     if (st.div_done) state_nx = ST_APP_RD;
			ST_APP_RD:    state_nx = ST_APP_WR1;
			ST_APP_WR1:   state_nx = ST_APP_WR2;
			ST_APP_WR2:   state_nx = ST_IDLE;
			ST_DEL_RD:    state_nx = ST_DEL_WR;
			ST_DEL_WR:    state_nx = ST_IDLE;
			ST_HEAD_RD:   state_nx = ST_HEAD_WT;
			ST_HEAD_WT:   state_nx = ST_SCAN_RD;
			ST_SCAN_RD:   state_nx = st.scan_go ? ST_SCAN_EX : ST_TICK_DONE;
			ST_SCAN_EX:   state_nx = ST_SCAN_RD;
			ST_TICK_DONE: state_nx = ST_IDLE;
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = DOP_NONE;
		cmd.div_sel = DS_N;
		busy        = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: cmd.op = DOP_CLEAR;
			ST_IDLE:  if (start) cmd.op = DOP_LOAD;
			ST_CHECK: begin
				cmd.last = 1'b1;
				case (st.action)
					ACT_ADD: begin
						cmd.kind = KIND_ADD;
						if (!st.idx_ok || st.idx_busy) begin
							cmd.emit   = 1'b1;
							cmd.status = STAT_BUSY;
						end else if (st.tmo_zero) begin
							cmd.emit   = 1'b1;
							cmd.status = STAT_TMO;
						end
					end
					ACT_DEL: begin
						cmd.kind = KIND_DEL;
						if (!st.idx_ok || !st.idx_busy) begin
							cmd.emit   = 1'b1;
							cmd.status = STAT_BUSY;
						end
					end
					default: cmd.last = 1'b0;
				endcase
			end
			ST_DIVN:  cmd.op = DOP_DIV_START;
			ST_WAITN: if (st.div_done) cmd.op = DOP_DIV_LATCH;
			ST_DIVQ: begin
				cmd.op      = DOP_DIV_START;
				cmd.div_sel = DS_Q;
			end
			ST_WAITQ: begin
				cmd.div_sel = DS_Q;
				if (st.div_done) cmd.op = DOP_DIV_LATCH;
			end
			ST_DIVO: begin
				cmd.op      = DOP_DIV_START;
				cmd.div_sel = DS_O;
			end
			ST_WAITO: begin
				cmd.div_sel = DS_O;
				if (st.div_done) cmd.op = DOP_DIV_LATCH;
			end
			ST_DIVS: begin
				cmd.op      = DOP_DIV_START;
				cmd.div_sel = DS_S;
			end
			ST_WAITS: begin
				cmd.div_sel = DS_S;
				if (st.div_done) cmd.op = DOP_DIV_LATCH;
			end
			ST_APP_RD:  cmd.op = DOP_APP_RD;
			ST_APP_WR1: cmd.op = DOP_APP_WR1;
			ST_APP_WR2: begin
				cmd.op   = DOP_APP_WR2;
				cmd.emit = 1'b1;
				cmd.kind = KIND_ADD;
				cmd.last = 1'b1;
			end
			ST_DEL_WR: begin
				cmd.op   = DOP_UNLINK;
				cmd.emit = 1'b1;
				cmd.kind = KIND_DEL;
				cmd.last = 1'b1;
			end
			ST_HEAD_WT: cmd.op = DOP_SCAN_INIT;
			ST_SCAN_RD: if (st.scan_go) cmd.op = DOP_SCAN_RD;
			ST_SCAN_EX: begin
				cmd.op   = DOP_SCAN_EX;
				cmd.emit = !st.rounds_nz;
				cmd.kind = KIND_EXP;
			end
			ST_TICK_DONE: begin
				cmd.op   = DOP_ADVANCE;
				cmd.emit = 1'b1;
				cmd.kind = KIND_DONE;
				cmd.last = 1'b1;
			end
			default: cmd.op = DOP_NONE;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/hwt_dp.sv @@
// ----------------------------------------------------------------------------
// hwt_dp
// Datapath: entry and slot stores, divider, wheel position and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_dp import hwt_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int SLOTS   = 512
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output dp_stat_t               st,
	input  wire logic [TICK_W-1:0] tick_cfg,
	input  wire logic [SPAN_W-1:0] span_cfg,
	input  wire logic [1:0]        action,
	input  wire logic [4:0]        entry_index,
	input  wire logic [TAG_W-1:0]  tag,
	input  wire logic [TMO_W-1:0]  timeout_ms,
	output logic                   result_valid,
	output logic [1:0]             kind,
	output logic [1:0]             status,
	output logic [4:0]             expired_index,
	output logic [TAG_W-1:0]       expired_tag,
	output logic                   last
);

	localparam int EW = $clog2(ENTRIES);
	localparam int SW = $clog2(SLOTS);
	localparam logic [LW-1:0] ENT_L = LW'(ENTRIES);

	// entry stores
	logic [TAG_W-1:0] tag_mem  [ENTRIES];
	logic [SW-1:0]    slot_mem [ENTRIES];
	logic [RND_W-1:0] rnd_mem  [ENTRIES];
	logic [LW-1:0]    next_mem [ENTRIES];
	logic [LW-1:0]    prev_mem [ENTRIES];
	// slot list ends
	logic [LW-1:0]    head_mem [SLOTS];
	logic [LW-1:0]    tail_mem [SLOTS];

	logic [ENTRIES-1:0] busy_q;

	logic [1:0]       action_q;
	logic [4:0]       idx_q;
	logic [TAG_W-1:0] tag_q;
	logic [TMO_W-1:0] tmo_q;
	logic [SW:0]      n_q;
	logic [RND_W-1:0] rounds_q;
	logic [DIV_D-1:0] rem_q;
	logic [OFF_W-1:0] off_q;
	logic [SW-1:0]    s_q;
	logic [SW-1:0]    cs_q;
	logic [LW-1:0]    e_q;
	logic [LW-1:0]    guard_q;
	logic [LW-1:0]    link_q;
	logic [SW-1:0]    clr_q;

	logic [TAG_W-1:0] tag_rd;
	logic [SW-1:0]    slot_rd;
	logic [RND_W-1:0] rnd_rd;
	logic [LW-1:0]    next_rd;
	logic [LW-1:0]    prev_rd;
	logic [LW-1:0]    head_rd;
	logic [LW-1:0]    tail_rd;

	logic             res_valid_q;
	logic [1:0]       kind_q;
	logic [1:0]       status_q;
	logic [4:0]       ridx_q;
	logic [TAG_W-1:0] rtag_q;
	logic             last_q;

	logic [TICK_W-1:0] tick_eff;
	logic [DIV_D-1:0]  span_eff;
	logic [LW-1:0]     idx_l;
	logic [EW-1:0]     idx_e;
	logic [EW-1:0]     e_e;
	logic [EW-1:0]     ent_ra;

	logic             dv_go;
	logic             dv_done;
	logic [DIV_N-1:0] dv_a;
	logic [DIV_D-1:0] dv_b;
	logic [DIV_N-1:0] dv_q;
	logic [DIV_D-1:0] dv_r;

	logic             hd_we, tl_we, nx_we, pv_we, sl_we, tg_we, rn_we;
	logic [SW-1:0]    hd_wa, tl_wa;
	logic [LW-1:0]    hd_wd, tl_wd;
	logic [EW-1:0]    nx_wa, pv_wa, sl_wa, tg_wa, rn_wa;
	logic [LW-1:0]    nx_wd, pv_wd;
	logic [RND_W-1:0] rn_wd;

	logic          expire;
	logic          p_ok, n_ok;
	logic [SW:0]   cs_inc;

	assign tick_eff = (tick_cfg < TICK_MIN) ? TICK_SUB : tick_cfg;
	always_comb begin
		if (span_cfg > SPAN_MAX) span_eff = DIV_D'(SPAN_MAX);
		else if (span_cfg == '0) span_eff = DIV_D'(1);
		else span_eff = span_cfg[DIV_D-1:0];
	end

	assign idx_l  = {1'b0, idx_q};
	assign idx_e  = idx_l[EW-1:0];
	assign e_e    = e_q[EW-1:0];
	assign ent_ra = (cmd.op == DOP_SCAN_RD) ? e_e : idx_e;
	assign p_ok   = prev_rd < ENT_L;
	assign n_ok   = next_rd < ENT_L;
	assign expire = (cmd.op == DOP_UNLINK) || ((cmd.op == DOP_SCAN_EX) && (rnd_rd == '0));
	assign cs_inc = {1'b0, cs_q} + 1'b1;

	assign st.clr_last  = (clr_q == SW'(SLOTS - 1));
	assign st.action    = action_q;
	assign st.idx_ok    = idx_l < ENT_L;
	assign st.idx_busy  = busy_q[idx_e];
	assign st.tmo_zero  = (tmo_q == '0);
	assign st.div_done  = dv_done;
	assign st.scan_go   = (e_q < ENT_L) && (guard_q < ENT_L);
	assign st.rounds_nz = (rnd_rd != '0);

	// divider operands
	always_comb begin
		case (cmd.div_sel)
			DS_N: begin
				dv_a = DIV_N'(span_eff) + DIV_N'(tick_eff) - DIV_N'(1);
				dv_b = tick_eff;
			end
			DS_Q: begin
				dv_a = tmo_q;
				dv_b = span_eff;
			end
			DS_O: begin
				dv_a = DIV_N'(rem_q) + DIV_N'(tick_eff) - DIV_N'(1);
				dv_b = tick_eff;
			end
			default: begin
				dv_a = DIV_N'(cs_q) + DIV_N'(off_q);
				dv_b = DIV_D'(n_q);
			end
		endcase
	end

	assign dv_go = (cmd.op == DOP_DIV_START);

	hwt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (dv_go),
		.dividend (dv_a),
		.divisor  (dv_b),
		.done     (dv_done),
		.quo      (dv_q),
		.rem      (dv_r)
	);

	// store write ports
	always_comb begin
		hd_we = 1'b0; hd_wa = s_q;   hd_wd = idx_l;
		tl_we = 1'b0; tl_wa = s_q;   tl_wd = idx_l;
		nx_we = 1'b0; nx_wa = idx_e; nx_wd = NIL;
		pv_we = 1'b0; pv_wa = idx_e; pv_wd = tail_rd;
		sl_we = 1'b0; sl_wa = idx_e;
		tg_we = 1'b0; tg_wa = idx_e;
		rn_we = 1'b0; rn_wa = idx_e; rn_wd = rounds_q;
		case (cmd.op)
			DOP_CLEAR: begin
				hd_we = 1'b1; hd_wa = clr_q; hd_wd = NIL;
				tl_we = 1'b1; tl_wa = clr_q; tl_wd = NIL;
			end
			DOP_APP_RD: begin
				tg_we = 1'b1;
				rn_we = 1'b1;
			end
			DOP_APP_WR1: begin
				tl_we = 1'b1;
				hd_we = !(tail_rd < ENT_L);
				nx_we = 1'b1;
				pv_we = 1'b1;
				sl_we = 1'b1;
			end
			DOP_APP_WR2: begin
				nx_we = link_q < ENT_L;
				nx_wa = link_q[EW-1:0];
				nx_wd = idx_l;
			end
			DOP_UNLINK, DOP_SCAN_EX: begin
				if (expire) begin
					hd_we = !p_ok; hd_wa = slot_rd; hd_wd = next_rd;
					tl_we = !n_ok; tl_wa = slot_rd; tl_wd = prev_rd;
					nx_we = p_ok;  nx_wa = prev_rd[EW-1:0]; nx_wd = next_rd;
					pv_we = n_ok;  pv_wa = next_rd[EW-1:0]; pv_wd = prev_rd;
				end else begin
					rn_we = 1'b1;
					rn_wa = e_e;
					rn_wd = rnd_rd - 1'b1;
				end
			end
			default: hd_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hd_we) head_mem[hd_wa] <= hd_wd;
		if (tl_we) tail_mem[tl_wa] <= tl_wd;
		head_rd <= head_mem[cs_q];
		tail_rd <= tail_mem[s_q];
	end

	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		if (sl_we) slot_mem[sl_wa] <= s_q;
		if (tg_we) tag_mem[tg_wa]  <= tag_q;
		if (rn_we) rnd_mem[rn_wa]  <= rn_wd;
		next_rd <= next_mem[ent_ra];
		prev_rd <= prev_mem[ent_ra];
		slot_rd <= slot_mem[ent_ra];
		tag_rd  <= tag_mem[ent_ra];
		rnd_rd  <= rnd_mem[ent_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			cs_q        <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= cmd.emit;
			case (cmd.op)
				DOP_CLEAR:   clr_q <= clr_q + 1'b1;
				DOP_APP_WR2: busy_q[idx_e] <= 1'b1;
				DOP_UNLINK:  busy_q[idx_e] <= 1'b0;
				DOP_SCAN_EX: if (expire) busy_q[e_e] <= 1'b0;
				DOP_ADVANCE: cs_q <= (cs_inc < n_q) ? cs_inc[SW-1:0] : '0;
				default:     clr_q <= clr_q;
			endcase
		end
	end

	// item and scan registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DOP_LOAD: begin
				action_q <= action;
				idx_q    <= entry_index;
				tag_q    <= tag;
				tmo_q    <= timeout_ms;
			end
			DOP_DIV_LATCH: begin
				case (cmd.div_sel)
					DS_N: n_q <= (dv_q > DIV_N'(SLOTS)) ? (SW+1)'(SLOTS) : dv_q[SW:0];
					DS_Q: begin
						rounds_q <= (dv_q[DIV_N-1:RND_W] != '0) ? '1 : dv_q[RND_W-1:0];
						rem_q    <= dv_r;
					end
					DS_O:    off_q <= dv_q[OFF_W-1:0];
					default: s_q   <= dv_r[SW-1:0];
				endcase
			end
			DOP_APP_WR1:   link_q <= tail_rd;
			DOP_SCAN_INIT: begin
				e_q     <= head_rd;
				guard_q <= '0;
			end
			DOP_SCAN_EX: begin
				e_q     <= next_rd;
				guard_q <= guard_q + 1'b1;
			end
			default: link_q <= link_q;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.kind;
			status_q <= cmd.status;
			last_q   <= cmd.last;
			case (cmd.kind)
				KIND_EXP: begin
					ridx_q <= e_q[4:0];
					rtag_q <= tag_rd;
				end
				KIND_DONE: begin
					ridx_q <= '0;
					rtag_q <= '0;
				end
				default: begin
					ridx_q <= idx_q;
					rtag_q <= '0;
				end
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign kind          = kind_q;
	assign status        = status_q;
	assign expired_index = ridx_q;
	assign expired_tag   = rtag_q;
	assign last          = last_q;

endmodule

`default_nettype wire

@@ rtl/hashed_timing_wheel.sv @@
// ----------------------------------------------------------------------------
// hashed_timing_wheel
// One-shot timer wheel with rounds: add, delete and tick commands.
// ----------------------------------------------------------------------------
//  channel   handshake                   payload
//  command   start, busy                 action, entry_index, tag, timeout_ms
//  result    result_valid (one cycle)    kind, status, expired_index,
//                                        expired_tag, last
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  Add: busy through four passes of the 27-step divider, then the append.
//  Delete: check, read and unlink states. Tick: one divider pass, then a
//  slot head read and a read/update pair per list entry on the entry stores.
//  After reset the slot store is cleared, with busy high.
//  Results come one per cycle at most and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_timing_wheel import hwt_pkg::*; #(
	parameter int ENTRIES = 32,
	parameter int SLOTS   = 512
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        action,
	input  wire logic [4:0]        entry_index,
	input  wire logic [TAG_W-1:0]  tag,
	input  wire logic [TMO_W-1:0]  timeout_ms,
	output logic                   result_valid,
	output logic [1:0]             kind,
	output logic [1:0]             status,
	output logic [4:0]             expired_index,
	output logic [TAG_W-1:0]       expired_tag,
	output logic                   last,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	logic [TICK_W-1:0] tick_q;
	logic [SPAN_W-1:0] span_q;
	logic              wr_en;
	ctrl_cmd_t         cmd;
	dp_stat_t          st;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_RST;
			span_q <= SPAN_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_TICK) tick_q <= pwdata[TICK_W-1:0];
			else span_q <= pwdata[SPAN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SPAN) ? {16'd0, span_q} : {19'd0, tick_q};

	hwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	hwt_dp #(
		.ENTRIES (ENTRIES),
		.SLOTS   (SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.tick_cfg      (tick_q),
		.span_cfg      (span_q),
		.action        (action),
		.entry_index   (entry_index),
		.tag           (tag),
		.timeout_ms    (timeout_ms),
		.result_valid  (result_valid),
		.kind          (kind),
		.status        (status),
		.expired_index (expired_index),
		.expired_tag   (expired_tag),
		.last          (last)
	);

endmodule

`default_nettype wire

@@ rtl/hwt_checker.sv @@
// ----------------------------------------------------------------------------
// hwt_checker
// Port-level checks of the timer wheel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_checker import hwt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        result_valid,
	input wire logic [1:0]  kind,
	input wire logic [1:0]  status,
	input wire logic [4:0]  expired_index,
	input wire logic [31:0] expired_tag,
	input wire logic        last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item accepted but block not busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("final result while still busy");

	a_exp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_EXP |-> !last)
		else $error("expiry marked last");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_ADD || kind == KIND_DEL) |-> last)
		else $error("ack not marked last");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_DONE |->
			expired_index == '0 && expired_tag == '0 && status == STAT_OK)
		else $error("tick done carries data");

endmodule

bind hashed_timing_wheel hwt_checker u_hwt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_valid  (result_valid),
	.kind          (kind),
	.status        (status),
	.expired_index (expired_index),
	.expired_tag   (expired_tag),
	.last          (last)
);

`default_nettype wire

@@ verif/hashed_timing_wheel_tb.sv @@
// ----------------------------------------------------------------------------
// hashed_timing_wheel_tb
// Drives add, delete, tick and no-op commands into the timer wheel under several
// tick and span settings and idle patterns. A scoreboard keeps its own copy
// of the wheel, predicts every ack, expiry and tick-done result, and checks
// each result as it appears.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hashed_timing_wheel_tb import hwt_pkg::*; ();

	localparam int N_ENT   = 32;
	localparam int N_SLOT  = 512;
	localparam int LIMIT   = 600000;
	localparam logic [1:0] ACT_NOP = 2'd3;

	typedef struct {
		logic [1:0]       kind;
		logic [1:0]       status;
		logic [4:0]       index;
		logic [TAG_W-1:0] tag;
		logic             last;
	} wheel_res_t;

	class wheel_scoreboard;
		logic [TICK_W-1:0] tick_reg;
		logic [SPAN_W-1:0] span_reg;
		bit               live[N_ENT];
		logic [TAG_W-1:0] tags[N_ENT];
		int unsigned      slot_of[N_ENT];
		logic [RND_W-1:0] rounds[N_ENT];
		int unsigned      nxt[N_ENT];
		int unsigned      prv[N_ENT];
		int unsigned      head[N_SLOT];
		int unsigned      tail[N_SLOT];
		int unsigned      cur;
		wheel_res_t       pending[$];
		int               errors;

		function new();
			tick_reg = TICK_RST;
			span_reg = SPAN_RST;
			for (int i = 0; i < N_ENT; i++) live[i] = 0;
			for (int i = 0; i < N_SLOT; i++) begin
				head[i] = NIL;
				tail[i] = NIL;
			end
			cur = 0;
			errors = 0;
		endfunction

		function int unsigned eff_tick();
			return (tick_reg < TICK_MIN) ? TICK_SUB : tick_reg;
		endfunction

		function int unsigned eff_span();
			int unsigned s;
			s = (span_reg > SPAN_MAX) ? SPAN_MAX : span_reg;
			return (s == 0) ? 1 : s;
		endfunction

		function int unsigned n_slots();
			int unsigned n;
			n = (eff_span() + eff_tick() - 1) / eff_tick();
			if (n > N_SLOT) n = N_SLOT;
			return (n == 0) ? 1 : n;
		endfunction

		function void push(logic [1:0] k, logic [1:0] st, logic [4:0] ix,
				logic [TAG_W-1:0] tg, logic lst);
			wheel_res_t r;
			r.kind = k;
			r.status = st;
			r.index = ix;
			r.tag = tg;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function void unlink(int unsigned e);
			int unsigned s;
			s = slot_of[e];
			if (prv[e] < N_ENT) nxt[prv[e]] = nxt[e]; else head[s] = nxt[e];
			if (nxt[e] < N_ENT) prv[nxt[e]] = prv[e]; else tail[s] = prv[e];
			live[e] = 0;
		endfunction

		function void note_input(logic [1:0] act, logic [4:0] ix,
				logic [TAG_W-1:0] tg, logic [TMO_W-1:0] tmo);
			longint unsigned rnd;
			int unsigned off, s, e, nx, guard;
			case (act)
				ACT_ADD: begin
					if (live[ix]) push(KIND_ADD, STAT_BUSY, ix, '0, 1'b1);
					else if (tmo == 0) push(KIND_ADD, STAT_TMO, ix, '0, 1'b1);
					else begin
						rnd = tmo / eff_span();
						if (rnd > 24'hFFFFFF) rnd = 24'hFFFFFF;
						off = ((tmo % eff_span()) + eff_tick() - 1) / eff_tick();
						s = (cur + off) % n_slots();
						tags[ix] = tg;
						rounds[ix] = RND_W'(rnd);
						slot_of[ix] = s;
						nxt[ix] = NIL;
						prv[ix] = tail[s];
						if (tail[s] < N_ENT) nxt[tail[s]] = ix; else head[s] = ix;
						tail[s] = ix;
						live[ix] = 1;
						push(KIND_ADD, STAT_OK, ix, '0, 1'b1);
					end
				end
				ACT_DEL: begin
					if (!live[ix]) push(KIND_DEL, STAT_BUSY, ix, '0, 1'b1);
					else begin
						unlink(ix);
						push(KIND_DEL, STAT_OK, ix, '0, 1'b1);
					end
				end
				ACT_TICK: begin
					e = head[cur % N_SLOT];
					guard = 0;
					while (e < N_ENT && guard < N_ENT) begin
						nx = nxt[e];
						if (rounds[e] != 0) rounds[e] = rounds[e] - 1'b1;
						else begin
							unlink(e);
							push(KIND_EXP, STAT_OK, 5'(e), tags[e], 1'b0);
						end
						e = nx;
						guard++;
					end
					push(KIND_DONE, STAT_OK, '0, '0, 1'b1);
					cur = (cur % N_SLOT) + 1;
					if (cur >= n_slots()) cur = 0;
				end
				default: ;
			endcase
		endfunction

		function void check(logic [1:0] k, logic [1:0] st, logic [4:0] ix,
				logic [TAG_W-1:0] tg, logic lst);
			wheel_res_t r;
			if (pending.size() == 0) begin
				$error("unexpected result kind=%0d index=%0d", k, ix);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (k !== r.kind) begin
				$error("kind: expected %0d, got %0d", r.kind, k);
				errors++;
			end
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				errors++;
			end
			if (ix !== r.index) begin
				$error("expired_index: expected %0d, got %0d", r.index, ix);
				errors++;
			end
			if (tg !== r.tag) begin
				$error("expired_tag: expected %h, got %h", r.tag, tg);
				errors++;
			end
			if (lst !== r.last) begin
				$error("last: expected %0d, got %0d", r.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] action = '0;
	logic [4:0] entry_index = '0;
	logic [TAG_W-1:0] tag = '0;
	logic [TMO_W-1:0] timeout_ms = '0;
	logic result_valid;
	logic [1:0] kind;
	logic [1:0] status;
	logic [4:0] expired_index;
	logic [TAG_W-1:0] expired_tag;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	wheel_scoreboard sb = new();
	int cycles = 0;

	hashed_timing_wheel dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid) sb.check(kind, status, expired_index, expired_tag, last);
			if (start && !busy) sb.note_input(action, entry_index, tag, timeout_ms);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("hashed_timing_wheel_tb failed");
			$finish;
		end
	end

	task automatic send_cmd(logic [1:0] act, logic [4:0] ix, logic [TAG_W-1:0] tg,
			logic [TMO_W-1:0] tmo, int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		action <= act;
		entry_index <= ix;
		tag <= tg;
		timeout_ms <= tmo;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0 || busy) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == {REG_TICK, 2'b00}) sb.tick_reg = value[TICK_W-1:0];
		else sb.span_reg = value[SPAN_W-1:0];
	endtask

	task automatic random_phase(int count, int idle_pct);
		int unsigned r, sp;
		logic [TMO_W-1:0] tmo;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			sp = sb.eff_span();
			if ($urandom_range(9) == 0) tmo = TMO_W'($urandom);
			else tmo = TMO_W'($urandom_range(3 * sp, 1));
			if (r < 38) send_cmd(ACT_ADD, 5'($urandom_range(31)), $urandom, tmo, idle_pct);
			else if (r < 55) send_cmd(ACT_DEL, 5'($urandom_range(31)), $urandom, tmo,
					idle_pct);
			else if (r < 96) send_cmd(ACT_TICK, 5'($urandom_range(31)), $urandom, tmo,
					idle_pct);
			else send_cmd(ACT_NOP, 5'($urandom_range(31)), $urandom, TMO_W'($urandom),
					idle_pct);
			if (i == count / 2 && $urandom_range(1)) drain();
		end
		drain();
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: acks, errors, expiry order, extremes
		write_reg({REG_TICK, 2'b00}, 32'd100);
		write_reg({REG_SPAN, 2'b00}, 32'd300);
		send_cmd(ACT_ADD, 5'd0, 32'h0, 27'd1, 0);
		send_cmd(ACT_ADD, 5'd31, 32'hFFFFFFFF, 27'd100, 0);
		send_cmd(ACT_ADD, 5'd7, 32'hA5A5_5A5A, 27'd50, 0);
		send_cmd(ACT_ADD, 5'd0, 32'h1, 27'd5, 0);
		send_cmd(ACT_ADD, 5'd9, 32'h2, 27'd0, 0);
		send_cmd(ACT_ADD, 5'd10, 32'h3, 27'h7FF_FFFF, 0);
		send_cmd(ACT_ADD, 5'd11, 32'h4, 27'd600, 0);
		send_cmd(ACT_DEL, 5'd12, 32'h0, 27'd0, 0);
		send_cmd(ACT_DEL, 5'd10, 32'h0, 27'd0, 0);
		send_cmd(ACT_NOP, 5'd3, 32'hFFFFFFFF, 27'h7FF_FFFF, 0);
		repeat (6) send_cmd(ACT_TICK, 5'd0, 32'h0, 27'd0, 0);
		drain();
		write_reg({REG_TICK, 2'b00}, 32'd0);
		write_reg({REG_SPAN, 2'b00}, 32'd0);
		send_cmd(ACT_ADD, 5'd20, 32'h5, 27'h7FF_FFFF, 0);
		send_cmd(ACT_TICK, 5'd0, 32'h0, 27'd0, 0);
		send_cmd(ACT_DEL, 5'd20, 32'h0, 27'd0, 0);
		drain();

		write_reg({REG_TICK, 2'b00}, 32'd100);
		write_reg({REG_SPAN, 2'b00}, 32'd1000);
		random_phase(45, 0);
		write_reg({REG_TICK, 2'b00}, 32'd8191);
		write_reg({REG_SPAN, 2'b00}, 32'd65535);
		random_phase(40, 64);
		write_reg({REG_TICK, 2'b00}, 32'd50);
		write_reg({REG_SPAN, 2'b00}, 32'd300);
		random_phase(45, 20);
		write_reg({REG_TICK, 2'b00}, 32'd1);
		write_reg({REG_SPAN, 2'b00}, 32'd1);
		random_phase(40, 64);
		write_reg({REG_TICK, 2'b00}, 32'd100);
		write_reg({REG_SPAN, 2'b00}, 32'd5000);
		random_phase(50, 0);

		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("hashed_timing_wheel_tb passed");
		end else begin
			$display("hashed_timing_wheel_tb failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hwt_pkg.sv
rtl/hwt_div.sv
rtl/hwt_ctrl.sv
rtl/hwt_dp.sv
rtl/hashed_timing_wheel.sv
rtl/hwt_checker.sv
verif/hashed_timing_wheel_tb.sv
